>>> hdl/s2d_pkg.sv
package s2d_pkg;

    // Field and arithmetic widths.
    localparam int PIX_W      = 8;
    localparam int ERR_W      = 9;
    localparam int SUM_W      = 11;
    localparam int LW_W       = 13;
    localparam int TH_W       = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [LW_W-1:0] RESET_LINE_WIDTH = 13'd1024;
    localparam logic [TH_W-1:0] RESET_THRESHOLD  = 8'd128;

    // Default largest row length held by the line store.
    localparam int DEF_MAX_WIDTH = 4096;

    // Saturation and output levels.
    localparam logic signed [SUM_W-1:0] SUM_MAX = 11'sd255;
    localparam logic signed [ERR_W-1:0] ERR_MAX = 9'sd255;

    // Diffusion weights, in sixteenths.
    localparam logic [2:0] WT_FOUR  = 3'd4;
    localparam logic [2:0] WT_THREE = 3'd3;
    localparam logic [2:0] WT_TWO   = 3'd2;
    localparam logic [2:0] WT_ONE   = 3'd1;

    // Input FIFO between the front and the back.
    localparam int FQ_DEPTH = 4;
    localparam int FQ_PW    = 2;
    localparam int FQ_CW    = 3;

    // Write queue in front of the line store.
    localparam int WQ_DEPTH = 4;
    localparam int WQ_PW    = 2;
    localparam int WQ_CW    = 3;

    // Number of line store writes that one pixel can raise.
    localparam int WR_PORTS = 3;

    typedef struct packed {
        logic [PIX_W-1:0] gray;
        logic             frame_start;
    } t_in;

    typedef struct packed {
        logic ink;
        logic line_end;
    } t_out;

    // Oldest buffered word as the back sees it.
    typedef struct packed {
        logic valid;
        t_in  word;
    } t_head;

    // Share of an error for a weight in sixteenths, rounded half away from zero.
    function automatic logic signed [ERR_W-1:0] share(
        input logic signed [ERR_W-1:0] err,
        input logic [2:0]              wt
    );
        logic [ERR_W-2:0] mag;
        logic [11:0]      prod;
        logic [ERR_W-1:0] q;
        mag  = err[ERR_W-1] ? (ERR_W-1)'(-err) : err[ERR_W-2:0];
        prod = 12'(mag) * 12'(wt) + 12'd8;
        q    = {1'b0, prod[11:4]};
        return err[ERR_W-1] ? -$signed(q) : $signed(q);
    endfunction

endpackage

>>> hdl/s2d_front.sv
module s2d_front
    import s2d_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_in   i_word,
    output t_head o_head,
    input  logic  i_pop
);

    t_in                r_buf [FQ_DEPTH];
    logic [FQ_PW-1:0]   r_wr_ptr;
    logic [FQ_PW-1:0]   r_rd_ptr;
    logic [FQ_CW-1:0]   r_count;
    logic               push;

    // The front takes a word whenever the buffer has a free slot.
    assign o_stall = (r_count == FQ_CW'(FQ_DEPTH));
    assign push    = i_valid && !o_stall;

    // Oldest word goes to the back.
    assign o_head.valid = (r_count != '0);
    assign o_head.word  = r_buf[r_rd_ptr];

    // Payload storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= i_word;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/s2d_store.sv
module s2d_store
    import s2d_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [CW-1:0]           i_rd_addr,
    output logic signed [ERR_W-1:0] o_rd_data,
    input  logic [WR_PORTS-1:0]     i_wr_valid,
    input  logic [CW-1:0]           i_wr_addr [WR_PORTS],
    input  logic signed [ERR_W-1:0] i_wr_data [WR_PORTS]
);

    logic signed [ERR_W-1:0] r_mem [MAX_WIDTH];
    logic signed [ERR_W-1:0] r_rd;
    logic [CW-1:0]           r_rd_addr;

    logic [CW-1:0]           r_q_addr [WQ_DEPTH];
    logic signed [ERR_W-1:0] r_q_data [WQ_DEPTH];
    logic [WQ_CW-1:0]        r_count;
    logic [CW-1:0]           n_q_addr [WQ_DEPTH];
    logic signed [ERR_W-1:0] n_q_data [WQ_DEPTH];
    logic [WQ_CW-1:0]        n_count;
    logic                    pop;

    logic                    r_last_valid;
    logic [CW-1:0]           r_last_addr;
    logic signed [ERR_W-1:0] r_last_data;

    // One store write a cycle drains the queue; a row end raises a short burst.
    assign pop = (r_count != '0);

    // Queue update: remove the head, then append the new writes in order.
    always_comb begin
        n_count = r_count - WQ_CW'(pop);
        for (int j = 0; j < WQ_DEPTH; j++) begin
            if (pop && j < WQ_DEPTH - 1) begin
                n_q_addr[j] = r_q_addr[j+1];
                n_q_data[j] = r_q_data[j+1];
            end else begin
                n_q_addr[j] = r_q_addr[j];
                n_q_data[j] = r_q_data[j];
            end
        end
        for (int k = 0; k < WR_PORTS; k++) begin
            if (i_wr_valid[k]) begin
                n_q_addr[n_count[WQ_PW-1:0]] = i_wr_addr[k];
                n_q_data[n_count[WQ_PW-1:0]] = i_wr_data[k];
                n_count = n_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < WQ_DEPTH; j++) begin
            r_q_addr[j] <= n_q_addr[j];
            r_q_data[j] <= n_q_data[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_last_valid <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_last_valid <= pop;
        end
    end

    // Line store: one write port fed by the queue head, one registered read.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_mem[r_q_addr[0]] <= r_q_data[0];
        end
        r_rd        <= r_mem[i_rd_addr];
        r_rd_addr   <= i_rd_addr;
        r_last_addr <= r_q_addr[0];
        r_last_data <= r_q_data[0];
    end

    // Forwarding: the newest pending write to the address wins over the array.
    always_comb begin
        o_rd_data = r_rd;
        if (r_last_valid && r_last_addr == r_rd_addr) begin
            o_rd_data = r_last_data;
        end
        for (int j = 0; j < WQ_DEPTH; j++) begin
            if (WQ_CW'(j) < r_count && r_q_addr[j] == r_rd_addr) begin
                o_rd_data = r_q_data[j];
            end
        end
    end

    // The queue never fills: at most three writes are ever pending.
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < WQ_CW'(WQ_DEPTH))
        else $error("Line store write queue overflow.");

endmodule

>>> hdl/s2d_back.sv
module s2d_back
    import s2d_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_head                   i_head,
    output logic                    o_pop,
    input  logic [LW_W-1:0]         i_line_width,
    input  logic [TH_W-1:0]         i_threshold,
    output logic [CW-1:0]           o_rd_addr,
    input  logic signed [ERR_W-1:0] i_rd_data,
    output logic [WR_PORTS-1:0]     o_wr_valid,
    output logic [CW-1:0]           o_wr_addr [WR_PORTS],
    output logic signed [ERR_W-1:0] o_wr_data [WR_PORTS],
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out                    o_out_word
);

    logic [CW-1:0]           r_column;
    logic signed [ERR_W-1:0] r_ahead_one;
    logic signed [ERR_W-1:0] r_ahead_two;
    logic signed [ERR_W-1:0] r_pend [4];
    logic                    r_first_row;
    logic                    r_out_valid;
    t_out                    r_out_word;

    logic [CW-1:0]           n_column;
    logic                    out_ready;
    logic                    fire;
    logic                    fs;
    logic [CW-1:0]           x;
    logic [CW-1:0]           x_plus1;
    logic [CW-1:0]           last_col;
    logic [31:0]             lw_ext;
    logic [31:0]             last_full;
    logic                    last;
    logic                    first;
    logic signed [ERR_W-1:0] ahead_one;
    logic signed [ERR_W-1:0] ahead_two;
    logic signed [ERR_W-1:0] pend [4];
    logic signed [ERR_W-1:0] above;
    logic signed [SUM_W-1:0] sum;
    logic [PIX_W-1:0]        level;
    logic                    white;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] sh_four;
    logic signed [ERR_W-1:0] sh_three;
    logic signed [ERR_W-1:0] sh_two;
    logic signed [ERR_W-1:0] sh_one;
    logic signed [ERR_W-1:0] acc [4];

    // A pixel is taken when a word waits and the output register has room.
    assign out_ready = !r_out_valid || !i_out_stall;
    assign fire      = i_head.valid && out_ready;
    assign o_pop     = fire;

    // Last column of a row, with the width held to 1..MAX_WIDTH.
    always_comb begin
        lw_ext = 32'(i_line_width);
        if (lw_ext == 32'd0) begin
            last_full = 32'd0;
        end else if (lw_ext > 32'(MAX_WIDTH)) begin
            last_full = 32'(MAX_WIDTH) - 32'd1;
        end else begin
            last_full = lw_ext - 32'd1;
        end
        last_col = last_full[CW-1:0];
    end

    // A frame start abandons the row in progress.
    always_comb begin
        fs        = i_head.word.frame_start;
        x         = fs ? '0 : r_column;
        x_plus1   = x + 1'b1;
        first     = fs || r_first_row;
        ahead_one = fs ? '0 : r_ahead_one;
        ahead_two = fs ? '0 : r_ahead_two;
        for (int k = 0; k < 4; k++) begin
            pend[k] = fs ? '0 : r_pend[k];
        end
        last  = (x >= last_col);
        above = first ? '0 : i_rd_data;
    end

    // Adjusted value, threshold and quantisation error.
    always_comb begin
        sum = $signed(SUM_W'({1'b0, i_head.word.gray})) + SUM_W'(ahead_one) + SUM_W'(above);
        if (sum < 0) begin
            level = '0;
        end else if (sum > SUM_MAX) begin
            level = '1;
        end else begin
            level = sum[PIX_W-1:0];
        end
        white = (level > i_threshold);
        err   = white ? $signed({1'b0, level}) - ERR_MAX : $signed({1'b0, level});
    end

    // Shares of the error and the next-row partial sums.
    always_comb begin
        sh_four  = share(err, WT_FOUR);
        sh_three = share(err, WT_THREE);
        sh_two   = share(err, WT_TWO);
        sh_one   = share(err, WT_ONE);
        acc[0]   = pend[0] + sh_one;
        acc[1]   = pend[1] + sh_two;
        acc[2]   = pend[2] + sh_three;
        acc[3]   = pend[3] + sh_two;
    end

    // Finished columns go to the line store; a row end flushes two more.
    always_comb begin
        o_wr_valid[0] = fire && (x >= CW'(2));
        o_wr_addr[0]  = x - CW'(2);
        o_wr_data[0]  = acc[0];
        o_wr_valid[1] = fire && last && (x >= CW'(1));
        o_wr_addr[1]  = x - CW'(1);
        o_wr_data[1]  = acc[1];
        o_wr_valid[2] = fire && last;
        o_wr_addr[2]  = x;
        o_wr_data[2]  = acc[2];
    end

    // The store is read ahead through its registered port, at the column of the next pixel.
    always_comb begin
        n_column = r_column;
        if (fire) begin
            n_column = last ? '0 : x_plus1;
        end
    end
    assign o_rd_addr = n_column;

    // Row state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_ahead_one <= '0;
            r_ahead_two <= '0;
            r_first_row <= 1'b1;
            for (int k = 0; k < 4; k++) begin
                r_pend[k] <= '0;
            end
        end else if (fire) begin
            r_column <= n_column;
            if (last) begin
                r_ahead_one <= '0;
                r_ahead_two <= '0;
                r_first_row <= 1'b0;
                for (int k = 0; k < 4; k++) begin
                    r_pend[k] <= '0;
                end
            end else begin
                r_ahead_one <= ahead_two + sh_four;
                r_ahead_two <= sh_three;
                r_first_row <= first;
                r_pend[0]   <= acc[1];
                r_pend[1]   <= acc[2];
                r_pend[2]   <= acc[3];
                r_pend[3]   <= sh_one;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_word.ink      <= white;
            r_out_word.line_end <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // After a row end the next pixel starts clean on a row that is not the first.
    a_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && last |=> r_column == '0 && r_ahead_one == '0 && r_ahead_two == '0
                         && !r_first_row)
        else $error("Row state not cleared after a row end.");

    // Within a row the column steps by one per pixel.
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !last |=> r_column == $past(x_plus1))
        else $error("Column did not advance by one.");

endmodule

>>> hdl/sierra_two_row_dither_top.sv
// Two-row Sierra error-diffusion dither: 8-bit gray pixels in raster order go in, one
// black or white bit per pixel comes out, in the same order, with a flag on the last
// pixel of each row. The block sustains one pixel per clock while the output does not
// stall; the result of a taken word is registered in the output register. That rate is
// set by the diffusion loop, where a pixel's error feeds the next pixel of its row, and
// by the line store's one write a cycle; the extra writes at a row end wait in a
// four-entry queue and drain through the store's single write port, whatever the pixel flow.
// The line store holds MAX_WIDTH errors of 9 bits and is never cleared: the first row
// of a frame does not use it.
// Raise frame_start on the first pixel of every image. Write line_width and threshold
// only while the block is idle; a width of 0 acts as 1 and one above MAX_WIDTH acts as
// MAX_WIDTH.
module sierra_two_row_dither_top
    import s2d_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [LW_W-1:0]         r_line_width;
    logic [TH_W-1:0]         r_threshold;
    t_head                   head;
    logic                    pop;
    logic [CW-1:0]           rd_addr;
    logic signed [ERR_W-1:0] rd_data;
    logic [WR_PORTS-1:0]     wr_valid;
    logic [CW-1:0]           wr_addr [WR_PORTS];
    logic signed [ERR_W-1:0] wr_data [WR_PORTS];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= RESET_LINE_WIDTH;
            r_threshold  <= RESET_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LINE_WIDTH: r_line_width <= i_cfg_data[LW_W-1:0];
                REG_THRESHOLD:  r_threshold  <= i_cfg_data[TH_W-1:0];
                default:        r_threshold  <= r_threshold;
            endcase
        end
    end

    // Input buffer.
    s2d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_word  (i_in_word),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Diffusion engine and output register.
    s2d_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .i_line_width (r_line_width),
        .i_threshold  (r_threshold),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_wr_valid   (wr_valid),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word)
    );

    // Next-row error store.
    s2d_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data),
        .i_wr_valid (wr_valid),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data)
    );

endmodule
